// ===== hw/rtl/glpw_pkg.sv =====
package glpw_pkg;

  // port width of the coordinate fields
  localparam int FIELD_W = 6;
  localparam int HEIGHT_W = 16;
  // distance covered by one move along an axis
  localparam int GRID_STEP = 2;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } walk_st_t;

endpackage

// ===== hw/rtl/grid_line_path_walker_core.sv =====
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    in_start_x, in_start_z, in_end_x, in_end_z, in_height
// out      output     out_valid / out_stall  out_point_x, out_point_z, out_point_height, out_last
//
// a path of n points (1 + x moves + z moves, up to 63) is walked one point a cycle while
// out_stall is low, and the walker returns through ST_IDLE to load the next command from the queue
// a two-entry command queue sits between the input classifier and the walker, so
// in_stall rises only when two paths wait behind the one being walked
// out_stall holds the output register and freezes the walker; reset is synchronous, rst_n low
module grid_line_path_walker_core #(
  parameter int COORD_BITS = 6
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [glpw_pkg::FIELD_W-1:0]   in_start_x,
  input  logic signed [glpw_pkg::FIELD_W-1:0]   in_start_z,
  input  logic signed [glpw_pkg::FIELD_W-1:0]   in_end_x,
  input  logic signed [glpw_pkg::FIELD_W-1:0]   in_end_z,
  input  logic signed [glpw_pkg::HEIGHT_W-1:0]  in_height,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [glpw_pkg::FIELD_W-1:0]   out_point_x,
  output logic signed [glpw_pkg::FIELD_W-1:0]   out_point_z,
  output logic signed [glpw_pkg::HEIGHT_W-1:0]  out_point_height,
  output logic                                  out_last
);
  import glpw_pkg::*;

  localparam int QW = 4 * COORD_BITS + HEIGHT_W;

  logic [QW-1:0] cmd, q_data;
  logic          q_full, q_valid, q_pop, push;

  assign in_stall = q_full;
  assign push = in_valid && !q_full;

  glpw_front #(.CB(COORD_BITS), .QW(QW)) u_front (
    .start_x(in_start_x),
    .start_z(in_start_z),
    .end_x  (in_end_x),
    .end_z  (in_end_z),
    .height (in_height),
    .cmd    (cmd)
  );

  glpw_queue #(.QW(QW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wdata   (cmd),
    .full    (q_full),
    .nonempty(q_valid),
    .pop     (q_pop),
    .rdata   (q_data)
  );

  glpw_back #(.CB(COORD_BITS), .QW(QW)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_x     (out_point_x),
    .out_point_z     (out_point_z),
    .out_point_height(out_point_height),
    .out_last        (out_last)
  );

endmodule

// ===== hw/rtl/glpw_front.sv =====
module glpw_front #(
  parameter int CB = 6,
  parameter int QW = 4 * CB + 16
) (
  input  logic signed [glpw_pkg::FIELD_W-1:0]  start_x,
  input  logic signed [glpw_pkg::FIELD_W-1:0]  start_z,
  input  logic signed [glpw_pkg::FIELD_W-1:0]  end_x,
  input  logic signed [glpw_pkg::FIELD_W-1:0]  end_z,
  input  logic signed [glpw_pkg::HEIGHT_W-1:0] height,
  output logic [QW-1:0]                        cmd
);
  import glpw_pkg::*;

  logic [CB-1:0] x0, z0, x1, z1;
  logic [CB:0]   dx, dz, adx, adz;
  logic [CB-2:0] tx, tz;
  logic          neg_x, neg_z;

  // snap down to the even grid: clear bit 0
  assign x0 = {start_x[CB-1:1], 1'b0};
  assign z0 = {start_z[CB-1:1], 1'b0};
  assign x1 = {end_x[CB-1:1], 1'b0};
  assign z1 = {end_z[CB-1:1], 1'b0};

  assign dx = {x1[CB-1], x1} - {x0[CB-1], x0};
  assign dz = {z1[CB-1], z1} - {z0[CB-1], z0};
  assign neg_x = dx[CB];
  assign neg_z = dz[CB];
  assign adx = neg_x ? (~dx + 1'b1) : dx;
  assign adz = neg_z ? (~dz + 1'b1) : dz;
  // move counts: half the absolute distance
  assign tx = adx[CB-1:1];
  assign tz = adz[CB-1:1];

  assign cmd = {height, neg_z, neg_x, tz, tx, z0, x0};

endmodule

// ===== hw/rtl/glpw_queue.sv =====
module glpw_queue #(
  parameter int QW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [QW-1:0] wdata,
  output logic          full,
  output logic          nonempty,
  input  logic          pop,
  output logic [QW-1:0] rdata
);

  logic [QW-1:0] mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full = (count_r == 2'd2);
  assign nonempty = (count_r != 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("pop from empty queue");

endmodule

// ===== hw/rtl/glpw_back.sv =====
module glpw_back #(
  parameter int CB = 6,
  parameter int QW = 4 * CB + 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  logic [QW-1:0]                         q_data,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [glpw_pkg::FIELD_W-1:0]   out_point_x,
  output logic signed [glpw_pkg::FIELD_W-1:0]   out_point_z,
  output logic signed [glpw_pkg::HEIGHT_W-1:0]  out_point_height,
  output logic                                  out_last
);
  import glpw_pkg::*;

  localparam int TW = CB - 1;
  localparam int AW = 2 * CB - 2;
  localparam int O_Z0 = CB;
  localparam int O_TX = 2 * CB;
  localparam int O_TZ = O_TX + TW;
  localparam int O_NX = O_TZ + TW;
  localparam int O_NZ = O_NX + 1;
  localparam int O_H = O_NZ + 1;

  walk_st_t st_r, st_nxt;

  logic [CB-1:0]       x_r, x_nxt, z_r, z_nxt;
  logic [TW-1:0]       mx_r, mx_nxt, mz_r, mz_nxt;
  logic [TW-1:0]       tx_r, tx_nxt, tz_r, tz_nxt;
  logic [AW-1:0]       ex_r, ex_nxt, ez_r, ez_nxt;
  logic                nx_r, nx_nxt, nz_r, nz_nxt;
  logic [HEIGHT_W-1:0] h_r, h_nxt;

  logic                ov_r, ov_nxt;
  logic [CB-1:0]       px_r, px_nxt, pz_r, pz_nxt;
  logic [HEIGHT_W-1:0] ph_r, ph_nxt;
  logic                pl_r, pl_nxt;

  logic load, canx, canz, fin, gox;

  // output register takes a new word when empty or being drained
  assign load = !ov_r || !out_stall;
  assign canx = (mx_r != tx_r);
  assign canz = (mz_r != tz_r);
  assign fin = !canx && !canz;
  // ex_r = (mx+1)*tz and ez_r = (mz+1)*tx, kept by repeated adds
  assign gox = (canx && canz) ? (ex_r <= ez_r) : canx;

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    x_nxt = x_r;
    z_nxt = z_r;
    mx_nxt = mx_r;
    mz_nxt = mz_r;
    tx_nxt = tx_r;
    tz_nxt = tz_r;
    ex_nxt = ex_r;
    ez_nxt = ez_r;
    nx_nxt = nx_r;
    nz_nxt = nz_r;
    h_nxt = h_r;
    ov_nxt = ov_r;
    px_nxt = px_r;
    pz_nxt = pz_r;
    ph_nxt = ph_r;
    pl_nxt = pl_r;
    case (st_r)
      ST_IDLE: begin
        if (load) begin
          ov_nxt = 1'b0;
        end
        if (q_valid) begin
          q_pop = 1'b1;
          st_nxt = ST_WALK;
          x_nxt = q_data[CB-1:0];
          z_nxt = q_data[O_Z0 +: CB];
          tx_nxt = q_data[O_TX +: TW];
          tz_nxt = q_data[O_TZ +: TW];
          nx_nxt = q_data[O_NX];
          nz_nxt = q_data[O_NZ];
          h_nxt = q_data[O_H +: HEIGHT_W];
          mx_nxt = '0;
          mz_nxt = '0;
          ex_nxt = AW'(q_data[O_TZ +: TW]);
          ez_nxt = AW'(q_data[O_TX +: TW]);
        end
      end
      ST_WALK: begin
        if (load) begin
          ov_nxt = 1'b1;
          px_nxt = x_r;
          pz_nxt = z_r;
          ph_nxt = h_r;
          pl_nxt = fin;
          if (fin) begin
            st_nxt = ST_IDLE;
          end else if (gox) begin
            x_nxt = nx_r ? x_r - CB'(GRID_STEP) : x_r + CB'(GRID_STEP);
            mx_nxt = mx_r + 1'b1;
            ex_nxt = ex_r + AW'(tz_r);
          end else begin
            z_nxt = nz_r ? z_r - CB'(GRID_STEP) : z_r + CB'(GRID_STEP);
            mz_nxt = mz_r + 1'b1;
            ez_nxt = ez_r + AW'(tx_r);
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    z_r <= z_nxt;
    mx_r <= mx_nxt;
    mz_r <= mz_nxt;
    tx_r <= tx_nxt;
    tz_r <= tz_nxt;
    ex_r <= ex_nxt;
    ez_r <= ez_nxt;
    nx_r <= nx_nxt;
    nz_r <= nz_nxt;
    h_r <= h_nxt;
    px_r <= px_nxt;
    pz_r <= pz_nxt;
    ph_r <= ph_nxt;
    pl_r <= pl_nxt;
  end

  assign out_valid = ov_r;
  assign out_point_x = FIELD_W'(px_r);
  assign out_point_z = FIELD_W'(pz_r);
  assign out_point_height = ph_r;
  assign out_last = pl_r;

  a_moves_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WALK) |-> (mx_r <= tx_r) && (mz_r <= tz_r))
    else $error("move count passed its total");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == ST_IDLE))
    else $error("queue popped while walking");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WALK) && load && fin |=> (st_r == ST_IDLE) && out_valid && out_last)
    else $error("final point did not close the path");

  a_even_point: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WALK) |-> !x_r[0] && !z_r[0])
    else $error("path point off the grid");

endmodule
